// File: src/lmb_pkg.sv
package lmb_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int PIX_W      = 8;
	localparam int ADDR_W     = $clog2(MAX_DIM);
	localparam int COORD_W    = 10;
	localparam int DIM_W      = COORD_W + 1;
	localparam int WIN        = 3;
	localparam int COL_SUM_W  = PIX_W + 2;
	localparam int WIN_SUM_W  = PIX_W + 4;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
	localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [COL_SUM_W-1:0] col_sum_t;
	typedef logic [COORD_W-1:0]   coord_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
		logic   last;
	} pos_t;

	// right_edge: last column of a row, neighbors on both sides are the same column
	// left_edge:  first column of a row, left neighbor reflects to the right one
	typedef struct packed {
		logic right_edge;
		logic left_edge;
	} win_ctrl_t;

	typedef struct packed {
		logic      emit;
		win_ctrl_t win;
		logic      top_refl;
		logic      bot_live;
		pix_t      pix;
		pos_t      pos;
	} s1_ctrl_t;

	typedef struct packed {
		logic bin;
		pos_t pos;
	} result_t;

endpackage

// File: src/lmb_line_buf.sv
module lmb_line_buf (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic                  wr_en,
	input  logic [lmb_pkg::ADDR_W-1:0] addr,
	input  logic                  parity,
	input  lmb_pkg::pix_t         wdata,
	output lmb_pkg::pix_t         top,
	output lmb_pkg::pix_t         mid
);
	import lmb_pkg::*;

	pix_t bank0 [MAX_DIM];
	pix_t bank1 [MAX_DIM];
	pix_t rd0_q;
	pix_t rd1_q;
	logic par_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd0_q <= bank0[addr];
		end
		if (wr_en && !parity) begin
			bank0[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd1_q <= bank1[addr];
		end
		if (wr_en && parity) begin
			bank1[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			par_q <= parity;
		end
	end

	// the bank of the current row parity holds two rows back, the other one row back
	assign top = par_q ? rd1_q : rd0_q;
	assign mid = par_q ? rd0_q : rd1_q;

endmodule

// File: src/lmb_cell.sv
module lmb_cell (
	input  logic               clk,
	input  logic               en,
	input  lmb_pkg::column_t   col_in,
	output lmb_pkg::column_t   col_out,
	output lmb_pkg::col_sum_t  col_sum
);
	import lmb_pkg::*;

	column_t col_q;

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign col_sum = COL_SUM_W'(col_q.top) + COL_SUM_W'(col_q.mid) + COL_SUM_W'(col_q.bot);

endmodule

// File: src/lmb_thresh.sv
module lmb_thresh (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                move,
	input  logic                valid,
	input  lmb_pkg::win_ctrl_t  win,
	input  lmb_pkg::pos_t       pos,
	input  lmb_pkg::col_sum_t   sum_new,
	input  lmb_pkg::col_sum_t   sum_mid,
	input  lmb_pkg::col_sum_t   sum_old,
	input  lmb_pkg::pix_t       center,
	output logic                res_valid,
	output lmb_pkg::result_t    res
);
	import lmb_pkg::*;

	col_sum_t               left_sum;
	col_sum_t               right_sum;
	logic [WIN_SUM_W-1:0]   total;
	logic [WIN_SUM_W-1:0]   center9;

	logic                   v_s3;
	logic [WIN_SUM_W-1:0]   total_s3;
	logic [WIN_SUM_W-1:0]   center9_s3;
	pos_t                   pos_s3;

	always_comb begin
		if (win.right_edge) begin
			left_sum  = sum_old;
			right_sum = sum_old;
		end else begin
			left_sum  = win.left_edge ? sum_new : sum_old;
			right_sum = sum_new;
		end
		total   = WIN_SUM_W'(left_sum) + WIN_SUM_W'(sum_mid) + WIN_SUM_W'(right_sum);
		center9 = WIN_SUM_W'({center, 3'b000}) + WIN_SUM_W'(center);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (move) begin
			v_s3 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			total_s3   <= total;
			center9_s3 <= center9;
			pos_s3     <= pos;
		end
	end

	assign res_valid = v_s3;
	assign res.bin   = center9_s3 > total_s3;
	assign res.pos   = pos_s3;

endmodule

// File: src/local_mean_binarize_3x3.sv
// channel   | handshake             | payload
// request   | pix_valid / pix_stall | op, pixel
// result    | bin_valid / bin_stall | bin, out_row, out_col, last_of_image
// config    | dim_we                | dim_wdata
//
// One request per cycle while pix_stall is low; a result passes through the line buffer read,
// window shift, sum and compare steps.
// Reset clears the counters, the valid flags and sets the dimension to 1024.
// A stalled result is held in a one-entry skid register; requests stall only while it is full.
module local_mean_binarize_3x3 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic                          op,
	input  lmb_pkg::pix_t                 pixel,
	output logic                          bin_valid,
	input  logic                          bin_stall,
	output logic                          bin,
	output logic [lmb_pkg::COORD_W-1:0]   out_row,
	output logic [lmb_pkg::COORD_W-1:0]   out_col,
	output logic                          last_of_image,
	input  logic                          dim_we,
	input  logic [lmb_pkg::DIM_W-1:0]     dim_wdata
);
	import lmb_pkg::*;

	logic [DIM_W-1:0]   dim_q;
	logic [DIM_W-1:0]   row_q;
	coord_t             col_q;
	logic [DIM_W-1:0]   dim_clamped;
	logic [DIM_W-1:0]   col_inc;

	logic               move;
	logic               take;
	logic               pix_ok;
	logic               adv;
	logic               drain_end;
	logic               col_zero;
	logic               emit_a;
	logic               emit_b;
	s1_ctrl_t           ctrl;

	logic               v_s1;
	s1_ctrl_t           ctrl_s1;
	pix_t               top_raw;
	pix_t               mid_raw;
	column_t            new_col;
	logic               shift_en;

	column_t            chain [WIN+1];
	col_sum_t           sums [WIN];

	logic               v_s2;
	win_ctrl_t          win_s2;
	pos_t               pos_s2;

	logic               res_valid;
	result_t            res;
	logic               o_load;
	logic               out_take;
	logic               o_v_q;
	result_t            o_q;
	logic               skid_v_q;
	result_t            skid_q;

	// front end: position counters and item classification
	assign move      = !skid_v_q;
	assign pix_stall = skid_v_q;
	assign take      = pix_valid && move;
	assign pix_ok    = row_q < dim_q;
	assign adv       = take && ((op == OP_PIXEL) ? pix_ok : !pix_ok);
	assign drain_end = row_q > dim_q;
	assign col_zero  = col_q == '0;
	assign emit_a    = col_zero && (row_q >= DIM_W'(2));
	assign emit_b    = !drain_end && !col_zero && (row_q != '0);
	assign col_inc   = {1'b0, col_q} + DIM_W'(1);

	always_comb begin
		if (dim_wdata < DIM_MIN) begin
			dim_clamped = DIM_MIN;
		end else if (dim_wdata > DIM_MAX) begin
			dim_clamped = DIM_MAX;
		end else begin
			dim_clamped = dim_wdata;
		end
	end

	always_comb begin
		ctrl.emit           = emit_a || emit_b;
		ctrl.win.right_edge = col_zero;
		ctrl.win.left_edge  = col_q == COORD_W'(1);
		ctrl.top_refl       = row_q == DIM_W'(1);
		ctrl.bot_live       = pix_ok;
		ctrl.pix            = pixel;
		if (col_zero) begin
			ctrl.pos.row = COORD_W'(row_q - DIM_W'(2));
			ctrl.pos.col = COORD_W'(dim_q - DIM_W'(1));
		end else begin
			ctrl.pos.row = COORD_W'(row_q - DIM_W'(1));
			ctrl.pos.col = col_q - COORD_W'(1);
		end
		ctrl.pos.last = drain_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
			row_q <= '0;
			col_q <= '0;
		end else if (dim_we) begin
			dim_q <= dim_clamped;
			row_q <= '0;
			col_q <= '0;
		end else if (adv) begin
			if (drain_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_inc >= dim_q) begin
				row_q <= row_q + DIM_W'(1);
				col_q <= '0;
			end else begin
				col_q <= COORD_W'(col_inc);
			end
		end
	end

	lmb_line_buf u_line_buf (
		.clk    (clk),
		.rd_en  (adv),
		.wr_en  (adv && pix_ok),
		.addr   (col_q[ADDR_W-1:0]),
		.parity (row_q[0]),
		.wdata  (pixel),
		.top    (top_raw),
		.mid    (mid_raw)
	);

	// stage 1: build the new column and shift it into the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (move) begin
			v_s1 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			ctrl_s1 <= ctrl;
		end
	end

	always_comb begin
		new_col.bot = ctrl_s1.bot_live ? ctrl_s1.pix : top_raw;
		new_col.top = ctrl_s1.top_refl ? new_col.bot : top_raw;
		new_col.mid = mid_raw;
	end

	assign shift_en = move && v_s1;
	assign chain[0] = new_col;

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		lmb_cell u_cell (
			.clk     (clk),
			.en      (shift_en),
			.col_in  (chain[i]),
			.col_out (chain[i+1]),
			.col_sum (sums[i])
		);
	end

	// stage 2: window is current for this item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (move) begin
			v_s2 <= v_s1 && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			win_s2 <= ctrl_s1.win;
			pos_s2 <= ctrl_s1.pos;
		end
	end

	lmb_thresh u_thresh (
		.clk       (clk),
		.arst_n    (arst_n),
		.move      (move),
		.valid     (v_s2),
		.win       (win_s2),
		.pos       (pos_s2),
		.sum_new   (sums[0]),
		.sum_mid   (sums[1]),
		.sum_old   (sums[2]),
		.center    (chain[2].mid),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register with skid entry
	assign o_load   = res_valid && move;
	assign out_take = o_v_q && !bin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q    <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (o_load) begin
			if (o_v_q && !out_take) begin
				skid_v_q <= 1'b1;
			end
			o_v_q <= 1'b1;
		end else if (out_take) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				o_q <= skid_q;
			end
		end else if (o_load) begin
			if (o_v_q && !out_take) begin
				skid_q <= res;
			end else begin
				o_q <= res;
			end
		end
	end

	assign bin_valid     = o_v_q;
	assign bin           = o_q.bin;
	assign out_row       = o_q.pos.row;
	assign out_col       = o_q.pos.col;
	assign last_of_image = o_q.pos.last;

endmodule
